// File: hw/rtl/sgsd_pkg.sv
// Package with the shared types, constants and register codes of the silence gap detector.
package sgsd_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 16;
   localparam int SUM_W               = 48;
   localparam int COUNT_W             = 16;
   localparam int TIME_W              = 32;
   localparam int LIMIT_W             = 42;
   localparam int KIND_W              = 2;
   localparam int CSR_INDEX_W         = 3;
   localparam int CSR_DATA_W          = 42;
   localparam int QUEUE_DEPTH         = 4;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET        = LIMIT_W'(4366);
   localparam logic [COUNT_W-1:0] SILENCE_MAX_RESET  = COUNT_W'(620);
   localparam logic [COUNT_W-1:0] START_MAX_RESET    = COUNT_W'(100);
   localparam logic [TIME_W-1:0]  MERGE_WINDOW_RESET = TIME_W'(5100);
   localparam logic [TIME_W-1:0]  START_CHUNK_RESET  = TIME_W'(0);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LIMIT        = 3'd0,
      CSR_SILENCE_MAX  = 3'd1,
      CSR_START_MAX    = 3'd2,
      CSR_MERGE_WINDOW = 3'd3,
      CSR_START_CHUNK  = 3'd4
   } csr_index_type;

   typedef enum logic [KIND_W-1:0] {
      EV_AD_START = 2'd0,
      EV_AD_END   = 2'd1,
      EV_END_MOVE = 2'd2
   } event_kind_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] limit;
      logic [COUNT_W-1:0] silence_max;
      logic [COUNT_W-1:0] start_max;
      logic [TIME_W-1:0]  merge_window;
   } cfg_type;

   typedef struct packed {
      logic              load;
      logic [TIME_W-1:0] value;
   } time_load_type;

endpackage

// File: hw/rtl/sgsd_if.sv
// Stream interfaces for the sample words and the event words.
interface sgsd_req_if #(
   parameter int SAMPLE_BITS = sgsd_pkg::SAMPLE_BITS_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          chunk_end;

   modport source (output valid, output sample, output chunk_end, input ready);
   modport sink (input valid, input sample, input chunk_end, output ready);
endinterface

interface sgsd_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [sgsd_pkg::KIND_W-1:0]       event_kind;
   logic [sgsd_pkg::TIME_W-1:0]       event_time;

   modport source (output valid, output event_kind, output event_time, input ready);
   modport sink (input valid, input event_kind, input event_time, output ready);
endinterface

// File: hw/rtl/sgsd_queue.sv
// Short queue of chunk classifications between the front and the back.
module sgsd_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  logic push_loud,
   input  logic pop,
   output logic full,
   output logic head_valid,
   output logic head_loud
);

   localparam int DEPTH = sgsd_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic             loud_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_loud  = loud_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         loud_ff[wr_ptr_ff] <= push_loud;
      end
   end

endmodule

// File: hw/rtl/sgsd_front.sv
// Front end: squares each sample, sums a chunk and classifies it as loud or silent.
module sgsd_front #(
   parameter int SAMPLE_BITS = sgsd_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   sgsd_req_if.sink                       req_chan,
   input  logic [sgsd_pkg::LIMIT_W-1:0]   limit,
   input  logic                           queue_full,
   output logic                           push,
   output logic                           push_loud
);

   localparam int MAG_W = SAMPLE_BITS + 1;
   localparam int SQ_W  = 2 * SAMPLE_BITS;
   localparam int SUM_W = sgsd_pkg::SUM_W;

   logic signed [MAG_W-1:0] sample_ext;
   logic [MAG_W-1:0]        magnitude;
   logic [SQ_W-1:0]         square_in;
   logic                    stall;
   logic                    advance;

   logic                    sq_valid_ff;
   logic                    sq_end_ff;
   logic [SQ_W-1:0]         sq_ff;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [SUM_W:0]          sum_add;
   logic [SUM_W-1:0]        sum_sat;

   assign sample_ext = MAG_W'(req_chan.sample);
   assign magnitude  = sample_ext[MAG_W-1] ? MAG_W'(-sample_ext) : MAG_W'(sample_ext);
   assign square_in  = SQ_W'(magnitude * magnitude);

   assign stall          = sq_valid_ff && sq_end_ff && queue_full;
   assign advance        = !stall;
   assign req_chan.ready = advance;

   assign sum_add   = {1'b0, sum_ff} + (SUM_W + 1)'(sq_ff);
   assign sum_sat   = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
   assign push      = sq_valid_ff && sq_end_ff && advance;
   assign push_loud = !(sum_sat < SUM_W'(limit));

   always_comb begin
      sum_in = sum_ff;
      if (advance && sq_valid_ff) begin
         sum_in = sq_end_ff ? '0 : sum_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
         sum_ff      <= '0;
      end else begin
         sum_ff <= sum_in;
         if (advance) begin
            sq_valid_ff <= req_chan.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_ff     <= square_in;
         sq_end_ff <= req_chan.chunk_end;
      end
   end

endmodule

// File: hw/rtl/sgsd_back.sv
// Back end: silence counting, ad start and end decisions and the event output register.
module sgsd_back (
   input  logic                    clock,
   input  logic                    reset,
   input  sgsd_pkg::cfg_type       cfg,
   input  sgsd_pkg::time_load_type time_load,
   input  logic                    head_valid,
   input  logic                    head_loud,
   output logic                    pop,
   sgsd_rsp_if.source              rsp_chan
);

   localparam int COUNT_W = sgsd_pkg::COUNT_W;
   localparam int TIME_W  = sgsd_pkg::TIME_W;

   logic [COUNT_W-1:0]       count_ff, count_in;
   logic                     running_ff, running_in;
   logic [TIME_W-1:0]        chunk_ff, chunk_in;
   logic [TIME_W-1:0]        prev_end_ff, prev_end_in;
   logic                     have_prev_ff, have_prev_in;
   logic                     out_valid_ff, out_valid_in;
   sgsd_pkg::event_kind_type out_kind_ff, kind_in;
   logic [TIME_W-1:0]        out_time_ff;

   logic                     emit;
   logic                     boundary;
   logic [TIME_W-1:0]        gap;
   logic                     merge;

   assign pop      = head_valid && (!out_valid_ff || rsp_chan.ready);
   assign boundary = (count_ff != '0) && (count_ff <= cfg.silence_max);
   assign gap      = chunk_ff - prev_end_ff;
   assign merge    = have_prev_ff && (gap < cfg.merge_window);

   always_comb begin
      count_in     = count_ff;
      running_in   = running_ff;
      prev_end_in  = prev_end_ff;
      have_prev_in = have_prev_ff;
      chunk_in     = chunk_ff;
      emit         = 1'b0;
      kind_in      = sgsd_pkg::EV_AD_START;
      if (pop) begin
         chunk_in = chunk_ff + 1'b1;
         priority if (!head_loud) begin
            if (count_ff != {COUNT_W{1'b1}}) begin
               count_in = count_ff + 1'b1;
            end
         end else if (!running_ff) begin
            priority if (boundary && merge) begin
               prev_end_in = chunk_ff;
               count_in    = '0;
               emit        = 1'b1;
               kind_in     = sgsd_pkg::EV_END_MOVE;
            end else if (boundary && count_ff <= cfg.start_max) begin
               running_in = 1'b1;
               count_in   = '0;
               emit       = 1'b1;
               kind_in    = sgsd_pkg::EV_AD_START;
            end else if (!boundary && count_ff > cfg.start_max) begin
               count_in = '0;
            end else begin
               count_in = count_ff;
            end
         end else begin
            priority if (boundary) begin
               running_in   = 1'b0;
               count_in     = '0;
               prev_end_in  = chunk_ff;
               have_prev_in = 1'b1;
               emit         = 1'b1;
               kind_in      = sgsd_pkg::EV_AD_END;
            end else if (count_ff > cfg.silence_max) begin
               count_in = '0;
            end else begin
               count_in = count_ff;
            end
         end
      end
      if (time_load.load) begin
         chunk_in = time_load.value;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (pop) begin
         out_valid_in = emit;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         running_ff   <= 1'b0;
         chunk_ff     <= sgsd_pkg::START_CHUNK_RESET;
         prev_end_ff  <= '0;
         have_prev_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         running_ff   <= running_in;
         chunk_ff     <= chunk_in;
         prev_end_ff  <= prev_end_in;
         have_prev_ff <= have_prev_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         out_kind_ff <= kind_in;
         out_time_ff <= chunk_ff;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.event_kind = out_kind_ff;
   assign rsp_chan.event_time = out_time_ff;

endmodule

// File: hw/rtl/silence_gap_segment_detector_core.sv
// Top level of the silence gap detector: configuration registers, front, queue and back.
// An event word passes the square and sum register, the chunk queue and the output register.
// Throughput: one sample word per cycle via the square and sum stage if the queue has room.
// The back decides one chunk per cycle while its output is free; each side stalls alone.
// Reset (synchronous) restores the default registers, clears sum, counters and ad state,
// and sets the chunk time to the default start time; no clearing pass is needed.
module silence_gap_segment_detector_core #(
   parameter int SAMPLE_BITS = sgsd_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   sgsd_req_if.sink                          req_chan,
   sgsd_rsp_if.source                        rsp_chan,
   input  logic                              csr_we,
   input  logic [sgsd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sgsd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   sgsd_pkg::cfg_type       cfg_ff, cfg_in;
   sgsd_pkg::time_load_type time_load;
   logic                    queue_full;
   logic                    push;
   logic                    push_loud;
   logic                    pop;
   logic                    head_valid;
   logic                    head_loud;

   always_comb begin
      cfg_in          = cfg_ff;
      time_load.load  = 1'b0;
      time_load.value = csr_wdata[sgsd_pkg::TIME_W-1:0];
      if (csr_we) begin
         unique case (csr_index)
            sgsd_pkg::CSR_LIMIT: begin
               cfg_in.limit = csr_wdata[sgsd_pkg::LIMIT_W-1:0];
            end
            sgsd_pkg::CSR_SILENCE_MAX: begin
               cfg_in.silence_max = csr_wdata[sgsd_pkg::COUNT_W-1:0];
            end
            sgsd_pkg::CSR_START_MAX: begin
               cfg_in.start_max = csr_wdata[sgsd_pkg::COUNT_W-1:0];
            end
            sgsd_pkg::CSR_MERGE_WINDOW: begin
               cfg_in.merge_window = csr_wdata[sgsd_pkg::TIME_W-1:0];
            end
            sgsd_pkg::CSR_START_CHUNK: begin
               time_load.load = 1'b1;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.limit        <= sgsd_pkg::LIMIT_RESET;
         cfg_ff.silence_max  <= sgsd_pkg::SILENCE_MAX_RESET;
         cfg_ff.start_max    <= sgsd_pkg::START_MAX_RESET;
         cfg_ff.merge_window <= sgsd_pkg::MERGE_WINDOW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sgsd_front #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .limit      (cfg_ff.limit),
      .queue_full (queue_full),
      .push       (push),
      .push_loud  (push_loud)
   );

   sgsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_loud  (push_loud),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_loud  (head_loud)
   );

   sgsd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .time_load  (time_load),
      .head_valid (head_valid),
      .head_loud  (head_loud),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

// File: hw/rtl/sgsd_checker.sv
// Port level checks of the silence gap detector and their binding to the top level.
module sgsd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [sgsd_pkg::KIND_W-1:0]   event_kind,
   input logic [sgsd_pkg::TIME_W-1:0]   event_time
);

   logic                        last_valid_ff;
   logic [sgsd_pkg::KIND_W-1:0] last_kind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_valid_ff <= 1'b0;
         last_kind_ff  <= sgsd_pkg::EV_AD_START;
      end else if (rsp_valid && rsp_ready) begin
         last_valid_ff <= 1'b1;
         last_kind_ff  <= event_kind;
      end
   end

   // A stalled event word keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(event_kind) && $stable(event_time))
      else $error("event word changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("event word valid right after reset");

   // After an ad start the next event must end that ad.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && last_valid_ff && last_kind_ff == sgsd_pkg::EV_AD_START
      |-> event_kind == sgsd_pkg::EV_AD_END)
      else $error("ad start not followed by ad end");

   // An ad end can only follow an ad start.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && event_kind == sgsd_pkg::EV_AD_END
      |-> last_valid_ff && last_kind_ff == sgsd_pkg::EV_AD_START)
      else $error("ad end without a running ad");

endmodule

bind silence_gap_segment_detector_core sgsd_checker u_sgsd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .event_kind (rsp_chan.event_kind),
   .event_time (rsp_chan.event_time)
);

// File: bench/silence_gap_segment_detector_core_tb.sv
// Self-checking testbench of the silence gap segment detector core with its own event predictor.
`timescale 1ns / 100ps

module silence_gap_segment_detector_core_tb;
   import sgsd_pkg::*;

   localparam int SW            = SAMPLE_BITS_DEFAULT;
   localparam int SETTLE_CYCLES = 16;
   localparam int DRAIN_LIMIT   = 4000;

   typedef struct {
      event_kind_type    kind;
      logic [TIME_W-1:0] at;
   } break_event_t;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   sgsd_req_if #(.SAMPLE_BITS(SW)) req_chan ();
   sgsd_rsp_if rsp_chan ();

   silence_gap_segment_detector_core #(.SAMPLE_BITS(SW)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Register copies and detector state of the predictor.
   logic [LIMIT_W-1:0] cfg_limit;
   logic [COUNT_W-1:0] cfg_gap_max;
   logic [COUNT_W-1:0] cfg_open_max;
   logic [TIME_W-1:0]  cfg_merge;
   logic [TIME_W-1:0]  cfg_origin;
   logic [SUM_W-1:0]   sum_sq;
   logic [COUNT_W-1:0] quiet_chunks;
   logic               in_break;
   logic [TIME_W-1:0]  chunk_clock;
   logic [TIME_W-1:0]  last_end;
   logic               end_known;

   break_event_t events_due[$];
   int           mismatches = 0;
   int           words_sent = 0;
   bit           steady_flow = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("Regression FAIL");
      $finish;
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("%0t ns: mismatch: %s", $time, what);
   endtask

   function automatic int pick_gap();
      int r;
      if (steady_flow) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic reset_detector_copy();
      cfg_limit    = LIMIT_RESET;
      cfg_gap_max  = SILENCE_MAX_RESET;
      cfg_open_max = START_MAX_RESET;
      cfg_merge    = MERGE_WINDOW_RESET;
      cfg_origin   = START_CHUNK_RESET;
      sum_sq       = '0;
      quiet_chunks = '0;
      in_break     = 1'b0;
      chunk_clock  = START_CHUNK_RESET;
      last_end     = '0;
      end_known    = 1'b0;
      events_due.delete();
   endtask

   task automatic push_event(input event_kind_type kind);
      break_event_t ev;
      ev.kind = kind;
      ev.at   = chunk_clock;
      events_due.push_back(ev);
   endtask

   // The first loud chunk after a silence decides what the silence meant.
   task automatic decide_chunk();
      logic               loud;
      logic [COUNT_W-1:0] c;
      logic [TIME_W-1:0]  gap;
      loud = !(sum_sq < SUM_W'(cfg_limit));
      c    = quiet_chunks;
      if (!loud) begin
         if (quiet_chunks != '1) quiet_chunks++;
      end else if (!in_break) begin
         if (c != 0 && c <= cfg_gap_max) begin
            gap = chunk_clock - last_end;
            if (end_known && gap < cfg_merge) begin
               last_end     = chunk_clock;
               quiet_chunks = '0;
               push_event(EV_END_MOVE);
            end else if (c <= cfg_open_max) begin
               in_break     = 1'b1;
               quiet_chunks = '0;
               push_event(EV_AD_START);
            end
         end else if (c > cfg_open_max) begin
            quiet_chunks = '0;
         end
      end else begin
         if (c != 0 && c <= cfg_gap_max) begin
            in_break     = 1'b0;
            quiet_chunks = '0;
            last_end     = chunk_clock;
            end_known    = 1'b1;
            push_event(EV_AD_END);
         end else if (c > cfg_gap_max) begin
            quiet_chunks = '0;
         end
      end
   endtask

   task automatic predict_word(input logic signed [SW-1:0] s, input logic last);
      logic [SW:0]      mag;
      logic [2*SW+1:0]  sq;
      logic [SUM_W:0]   total;
      mag    = s[SW-1] ? -{s[SW-1], s} : {1'b0, s};
      sq     = mag * mag;
      total  = {1'b0, sum_sq} + sq;
      sum_sq = total[SUM_W] ? '1 : total[SUM_W-1:0];
      if (last) begin
         decide_chunk();
         sum_sq = '0;
         chunk_clock++;
      end
   endtask

   task automatic send_word(input logic signed [SW-1:0] s, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.sample    <= s;
      req_chan.chunk_end <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_word(s, last);
      words_sent++;
   endtask

   function automatic logic signed [SW-1:0] quiet_sample();
      return SW'(int'($urandom_range(0, 30)) - 15);
   endfunction

   function automatic logic signed [SW-1:0] big_sample();
      int unsigned v;
      v = $urandom_range(4096, 1 << (SW - 1));
      return $urandom_range(0, 1) ? SW'(-v) : SW'(v);
   endfunction

   function automatic int chunk_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
   endfunction

   // A loud chunk holds one large sample among random ones; a quiet chunk only small ones.
   task automatic send_chunk(input bit loud, input int n);
      int big_at;
      big_at = $urandom_range(0, n - 1);
      for (int i = 0; i < n; i++) begin
         if (!loud) send_word(quiet_sample(), i == n - 1);
         else if (i == big_at) send_word(big_sample(), i == n - 1);
         else send_word(SW'($urandom), i == n - 1);
      end
   endtask

   task automatic play_gaps(input int quiet_len);
      repeat (quiet_len) send_chunk(1'b0, chunk_len());
      send_chunk(1'b1, chunk_len());
   endtask

   task automatic settle_block();
      int n;
      n = 0;
      req_chan.valid <= 1'b0;
      while (events_due.size() != 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
      if (events_due.size() != 0) begin
         report_mismatch($sformatf("%0d expected event words never came", events_due.size()));
         events_due.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_LIMIT:        cfg_limit = value[LIMIT_W-1:0];
         CSR_SILENCE_MAX:  cfg_gap_max = value[COUNT_W-1:0];
         CSR_START_MAX:    cfg_open_max = value[COUNT_W-1:0];
         CSR_MERGE_WINDOW: cfg_merge = value[TIME_W-1:0];
         CSR_START_CHUNK: begin
            cfg_origin  = value[TIME_W-1:0];
            chunk_clock = cfg_origin;
         end
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Narrow registers get random junk in the unused upper bits of the write data.
   task automatic reconfigure(input logic [LIMIT_W-1:0] limit, input logic [COUNT_W-1:0] gap_max,
                              input logic [COUNT_W-1:0] open_max, input logic [TIME_W-1:0] merge,
                              input logic [TIME_W-1:0] origin);
      logic [CSR_DATA_W-1:0] junk;
      settle_block();
      junk = CSR_DATA_W'({$urandom, $urandom});
      write_reg(CSR_LIMIT, CSR_DATA_W'(limit));
      write_reg(CSR_SILENCE_MAX, {junk[CSR_DATA_W-1:COUNT_W], gap_max});
      write_reg(CSR_START_MAX, {junk[CSR_DATA_W-COUNT_W-1:0], open_max});
      write_reg(CSR_MERGE_WINDOW, {junk[CSR_DATA_W-1:TIME_W], merge});
      write_reg(CSR_START_CHUNK, {junk[CSR_DATA_W-TIME_W-1:0], origin});
   endtask

   always @(posedge clock) begin : check_events
      break_event_t due;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (events_due.size() == 0) begin
            report_mismatch($sformatf("unexpected event word kind %0d time %0d",
                                      rsp_chan.event_kind, rsp_chan.event_time));
         end else begin
            due = events_due.pop_front();
            if (rsp_chan.event_kind !== due.kind)
               report_mismatch($sformatf("event kind %0d, expected %s at time %0d",
                                         rsp_chan.event_kind, due.kind.name(), due.at));
            if (rsp_chan.event_time !== due.at)
               report_mismatch($sformatf("event time %0d, expected %0d (%s)",
                                         rsp_chan.event_time, due.at, due.kind.name()));
         end
      end
   end

   initial begin
      int hold;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         hold = pick_gap();
         if (hold > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // Defaults after reset: the first break cannot merge, later ones can.
   task automatic test_reset_defaults();
      send_word(SW'(32767), 1'b0);
      send_word(SW'(-32768), 1'b1);
      send_word(SW'(0), 1'b0);
      send_word(SW'(-1), 1'b0);
      send_word(SW'(1), 1'b1);
      send_chunk(1'b1, 2);
      play_gaps(2);
      play_gaps(1);
      play_gaps(3);
   endtask

   task automatic test_limit_edges();
      reconfigure(LIMIT_W'(10000), COUNT_W'(4), COUNT_W'(4), TIME_W'(8), TIME_W'(0));
      send_word(SW'(100), 1'b1);
      send_word(SW'(99), 1'b1);
      send_word(SW'(-100), 1'b1);
      send_word(SW'(-99), 1'b1);
      send_word(SW'(100), 1'b1);
      reconfigure('0, COUNT_W'(4), COUNT_W'(4), TIME_W'(8), TIME_W'(0));
      send_word(SW'(0), 1'b1);
      play_gaps(2);
      play_gaps(1);
   endtask

   task automatic test_register_extremes();
      reconfigure(LIMIT_RESET, '1, '1, '1, TIME_W'(32'hFFFF_FFFE));
      play_gaps(1);
      play_gaps(1);
      play_gaps(2);
      play_gaps(1);
      settle_block();
      for (int i = int'(CSR_START_CHUNK) + 1; i < (1 << CSR_INDEX_W); i++)
         write_reg(CSR_INDEX_W'(i), CSR_DATA_W'({$urandom, $urandom}));
      play_gaps(1);
      play_gaps(1);
      reconfigure(LIMIT_RESET, COUNT_W'(1), COUNT_W'(1), '0, '0);
      play_gaps(1);
      play_gaps(2);
      play_gaps(1);
      play_gaps(1);
      play_gaps(1);
   endtask

   task automatic test_random_traffic(input int total);
      int phases;
      int first;
      int r;
      int span;
      logic [LIMIT_W-1:0] limit;
      logic [COUNT_W-1:0] gap_max;
      logic [COUNT_W-1:0] open_max;
      logic [TIME_W-1:0]  merge;
      logic [TIME_W-1:0]  origin;
      phases = 6;
      for (int p = 0; p < phases; p++) begin
         r = $urandom_range(0, 9);
         limit = (r == 0) ? '0 : (r == 1) ? '1 : (r == 2) ? LIMIT_RESET :
                 LIMIT_W'($urandom_range(3000, 1 << 24));
         gap_max  = ($urandom_range(0, 9) == 0) ? COUNT_W'(1) : COUNT_W'($urandom_range(1, 8));
         open_max = ($urandom_range(0, 9) == 0) ? '1 : COUNT_W'($urandom_range(1, 8));
         r = $urandom_range(0, 9);
         merge = (r == 0) ? '0 : (r == 1) ? '1 : TIME_W'($urandom_range(1, 40));
         origin = ($urandom_range(0, 4) == 0) ? TIME_W'(32'hFFFF_FFF0) : TIME_W'($urandom);
         reconfigure(limit, gap_max, open_max, merge, origin);
         steady_flow = ($urandom_range(0, 3) == 0);
         span = ((gap_max > open_max) ? gap_max : open_max) + 2;
         if (span > 10) span = 10;
         first = words_sent;
         while (words_sent - first < total / phases) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
               r = chunk_len();
               for (int i = 0; i < r; i++) send_word(SW'($urandom), i == r - 1);
            end else begin
               play_gaps((r < 20) ? 0 : $urandom_range(1, span));
               repeat ($urandom_range(0, 2)) send_chunk(1'b1, chunk_len());
            end
         end
         steady_flow = 0;
      end
   endtask

   initial begin
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.sample    <= '0;
      req_chan.chunk_end <= 1'b0;
      csr_we             <= 1'b0;
      csr_index          <= CSR_LIMIT;
      csr_wdata          <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      reset_detector_copy();
      test_reset_defaults();
      test_limit_edges();
      test_register_extremes();
      test_random_traffic(1100);
      settle_block();
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
